@@ src/otc_pkg.sv @@
// ----------------------------------------------------------------------------
// otc_pkg
// Shared types, codes and constants of the OLED text console.
// ----------------------------------------------------------------------------
`default_nettype none

package otc_pkg;

    // Font geometry
    localparam int GLYPH_WIDTH  = 6;
    localparam int GLYPH_HEIGHT = 8;
    localparam int PAGE_ROWS    = 8;
    localparam int GLYPH_COUNT  = 256;

    localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_WIDTH;
    localparam int STORE_AW   = $clog2(STORE_SIZE);
    // glyph address of any 8-bit code, one column past the end included
    localparam int GADDR_W    = $clog2(256 * GLYPH_WIDTH + 1);
    localparam int GIDX_W     = $clog2(GLYPH_WIDTH);
    localparam int PAGE_SHIFT = $clog2(PAGE_ROWS);

    localparam int COLUMN_OFFSET = 2;

    // Controller command bytes
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [3:0] COL_LO_MASK = 4'hF;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // Operation codes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_END_X    = 2'd2;
    localparam logic [1:0] CFG_END_Y    = 2'd3;

    localparam int CFG_DW = 7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [4:0]  text_col;
        logic [2:0]  text_row;
        logic [10:0] font_addr;
        logic [7:0]  font_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_data;
        logic [7:0] repeat_count;
        logic       last;
    } out_item_t;

    // Which result byte the datapath builds
    typedef enum logic [2:0] {
        SRC_CLR_HI,
        SRC_CLR_LO,
        SRC_CLR_PAGE,
        SRC_FILL,
        SRC_POS_HI,
        SRC_POS_LO,
        SRC_POS_PAGE,
        SRC_GLYPH
    } res_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_CHK,
        ST_CLR_HI,
        ST_CLR_LO,
        ST_CLR_PAGE,
        ST_CLR_FILL,
        ST_POS_HI,
        ST_POS_LO,
        ST_POS_PAGE,
        ST_GLYPH
    } ctl_state_t;

    typedef struct packed {
        logic     take_put;
        logic     take_set;
        logic     take_load;
        logic     emit;
        res_src_t src;
        logic     clr_next;
    } ctl_cmd_t;

    typedef struct packed {
        logic wrap_now;
        logic brk;
        logic clr_more;
        logic fill_nonempty;
        logic glyph_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ src/otc_ctrl.sv @@
// ----------------------------------------------------------------------------
// otc_ctrl
// Sequencer: steps through line clear, position and glyph bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module otc_ctrl
    import otc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] operation,
    input  wire dp_stat_t   stat,
    output logic            s_ready,
    output ctl_cmd_t        cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && operation == OP_PUT) begin
                    state_next = stat.wrap_now ? ST_CLR_CHK : ST_POS_HI;
                end
            end
            ST_CLR_CHK: begin
                state_next = stat.clr_more ? ST_CLR_HI : ST_POS_HI;
            end
            ST_CLR_HI: begin
                if (stat.out_free) state_next = ST_CLR_LO;
            end
            ST_CLR_LO: begin
                if (stat.out_free) state_next = ST_CLR_PAGE;
            end
            ST_CLR_PAGE: begin
                if (stat.out_free) begin
                    state_next = stat.fill_nonempty ? ST_CLR_FILL : ST_CLR_CHK;
                end
            end
            ST_CLR_FILL: begin
                if (stat.out_free) state_next = ST_CLR_CHK;
            end
            ST_POS_HI: begin
                if (stat.out_free) state_next = ST_POS_LO;
            end
            ST_POS_LO: begin
                if (stat.out_free) state_next = ST_POS_PAGE;
            end
            ST_POS_PAGE: begin
                if (stat.out_free) state_next = stat.brk ? ST_IDLE : ST_GLYPH;
            end
            ST_GLYPH: begin
                if (stat.out_free && stat.glyph_last) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.take_put  = 1'b0;
        cmd.take_set  = 1'b0;
        cmd.take_load = 1'b0;
        cmd.emit      = 1'b0;
        cmd.src       = SRC_POS_HI;
        cmd.clr_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_put  = s_valid && operation == OP_PUT;
                cmd.take_set  = s_valid && operation == OP_SET;
                cmd.take_load = s_valid && operation == OP_LOAD;
            end
            ST_CLR_CHK: begin
            end
            ST_CLR_HI: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_CLR_HI;
            end
            ST_CLR_LO: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_CLR_LO;
            end
            ST_CLR_PAGE: begin
                cmd.emit     = stat.out_free;
                cmd.src      = SRC_CLR_PAGE;
                cmd.clr_next = stat.out_free && !stat.fill_nonempty;
            end
            ST_CLR_FILL: begin
                cmd.emit     = stat.out_free;
                cmd.src      = SRC_FILL;
                cmd.clr_next = stat.out_free;
            end
            ST_POS_HI: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_POS_HI;
            end
            ST_POS_LO: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_POS_LO;
            end
            ST_POS_PAGE: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_POS_PAGE;
            end
            ST_GLYPH: begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_GLYPH;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/otc_datapath.sv @@
// ----------------------------------------------------------------------------
// otc_datapath
// Area registers, cursor, font store and result register of the console.
// ----------------------------------------------------------------------------
`default_nettype none

module otc_datapath
    import otc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire in_item_t          s_data,
    input  wire ctl_cmd_t          cmd,
    output dp_stat_t               stat,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data
);

    localparam logic [7:0] GW8 = 8'(GLYPH_WIDTH);
    localparam logic [7:0] GH8 = 8'(GLYPH_HEIGHT);
    localparam logic [GIDX_W-1:0] GIDX_LAST = GIDX_W'(GLYPH_WIDTH - 1);

    // area registers
    logic [6:0] org_x_reg;
    logic [5:0] org_y_reg;
    logic [6:0] lim_x_reg;
    logic [5:0] lim_y_reg;

    // cursor and per-character state
    logic [7:0]         cursor_x_reg;
    logic [7:0]         cursor_y_reg;
    logic [7:0]         next_x_reg;
    logic               brk_reg;
    logic [8:0]         clr_y_reg;
    logic [7:0]         clr_end_reg;
    logic [GADDR_W-1:0] gaddr_reg;
    logic [GIDX_W-1:0]  gidx_reg;

    // font store
    logic [7:0] font_mem [STORE_SIZE];
    logic [7:0] rdata_reg;
    logic       rd_ok_reg;

    logic      out_valid_reg;
    out_item_t out_reg;

    logic [7:0] org_x8;
    logic [7:0] org_y8;
    logic [7:0] lim_x8;
    logic [7:0] lim_y8;

    assign org_x8 = {1'b0, org_x_reg};
    assign org_y8 = {2'b0, org_y_reg};
    assign lim_x8 = {1'b0, lim_x_reg};
    assign lim_y8 = {2'b0, lim_y_reg};

    // wrap decision for the character on the input
    logic       brk_now;
    logic [7:0] sum_x;
    logic [7:0] cy_step;
    logic [7:0] ey_step;
    logic [7:0] wrap_y;
    logic [7:0] wrap_ey;

    always_comb begin
        brk_now = s_data.char_code == CHAR_CR || s_data.char_code == CHAR_LF;
        sum_x   = cursor_x_reg + GW8;
        cy_step = cursor_y_reg + GH8;
        ey_step = cy_step + GH8;
        if (ey_step > lim_y8) begin
            wrap_y  = org_y8;
            wrap_ey = org_y8 + GH8;
        end else begin
            wrap_y  = cy_step;
            wrap_ey = ey_step;
        end
    end

    // set position
    logic [7:0] set_x;
    logic [7:0] set_y;

    always_comb begin
        set_x = org_x8 + 8'(s_data.text_col * GW8);
        set_y = org_y8 + 8'(s_data.text_row * GH8);
        if (set_x > lim_x8) set_x = org_x8;
        if (set_y > lim_y8) set_y = org_y8;
    end

    logic glyph_step;
    logic glyph_last;
    logic out_free;

    assign glyph_step = cmd.emit && cmd.src == SRC_GLYPH;
    assign glyph_last = gidx_reg == GIDX_LAST;
    assign out_free   = !out_valid_reg || m_ready;

    always_comb begin
        stat.wrap_now      = brk_now || sum_x > lim_x8;
        stat.brk           = brk_reg;
        stat.clr_more      = clr_y_reg < {1'b0, clr_end_reg};
        stat.fill_nonempty = lim_x_reg > org_x_reg;
        stat.glyph_last    = glyph_last;
        stat.out_free      = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            lim_x_reg <= 7'd127;
            lim_y_reg <= 6'd63;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y: org_y_reg <= cfg_wdata[5:0];
                CFG_END_X:    lim_x_reg <= cfg_wdata;
                CFG_END_Y:    lim_y_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            if (cmd.take_put) begin
                if (stat.wrap_now) begin
                    cursor_x_reg <= org_x8;
                    cursor_y_reg <= wrap_y;
                end
            end else if (cmd.take_set) begin
                cursor_x_reg <= set_x;
                cursor_y_reg <= set_y;
            end else if (glyph_step && glyph_last) begin
                cursor_x_reg <= next_x_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_put) begin
            brk_reg     <= brk_now;
            clr_y_reg   <= {1'b0, wrap_y};
            clr_end_reg <= wrap_ey;
            next_x_reg  <= stat.wrap_now ? org_x8 + GW8 : sum_x;
            gaddr_reg   <= GADDR_W'(s_data.char_code) * GADDR_W'(GLYPH_WIDTH);
            gidx_reg    <= '0;
        end else begin
            if (cmd.clr_next) begin
                clr_y_reg <= clr_y_reg + 9'(PAGE_ROWS);
            end
            if (glyph_step) begin
                gaddr_reg <= gaddr_reg + 1'b1;
                gidx_reg  <= gidx_reg + 1'b1;
            end
        end
    end

    // read one column ahead while a glyph byte goes out
    logic [GADDR_W-1:0] rd_addr;
    logic               rd_en;

    assign rd_addr = glyph_step ? gaddr_reg + 1'b1 : gaddr_reg;
    assign rd_en   = {1'b0, rd_addr} < (GADDR_W + 1)'(STORE_SIZE);

    always_ff @(posedge aclk) begin
        if (cmd.take_load && {1'b0, s_data.font_addr} < 12'(STORE_SIZE)) begin
            font_mem[s_data.font_addr[STORE_AW-1:0]] <= s_data.font_byte;
        end
        if (rd_en) begin
            rdata_reg <= font_mem[rd_addr[STORE_AW-1:0]];
        end
        rd_ok_reg <= rd_en;
    end

    // result byte
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] col;
    out_item_t  res;

    always_comb begin
        if (cmd.src == SRC_CLR_HI || cmd.src == SRC_CLR_LO || cmd.src == SRC_CLR_PAGE) begin
            pos_x = org_x8;
            pos_y = clr_y_reg[7:0];
        end else begin
            pos_x = cursor_x_reg;
            pos_y = cursor_y_reg;
        end
        col = pos_x + 8'(COLUMN_OFFSET);

        res.is_data      = 1'b0;
        res.repeat_count = 8'd1;
        res.last         = 1'b0;
        unique case (cmd.src)
            SRC_CLR_HI, SRC_POS_HI: begin
                res.byte_value = CMD_COL_HI | {4'h0, col[7:4]};
            end
            SRC_CLR_LO, SRC_POS_LO: begin
                res.byte_value = {4'h0, col[3:0] & COL_LO_MASK};
            end
            SRC_CLR_PAGE: begin
                res.byte_value = CMD_PAGE + (pos_y >> PAGE_SHIFT);
            end
            SRC_POS_PAGE: begin
                res.byte_value = CMD_PAGE + (pos_y >> PAGE_SHIFT);
                res.last       = brk_reg;
            end
            SRC_FILL: begin
                res.byte_value   = 8'h00;
                res.is_data      = 1'b1;
                res.repeat_count = {1'b0, lim_x_reg - org_x_reg};
            end
            SRC_GLYPH: begin
                res.byte_value = rd_ok_reg ? rdata_reg : 8'h00;
                res.is_data    = 1'b1;
                res.last       = glyph_last;
            end
            default: begin
                res.byte_value = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ src/oled_text_console_stream.sv @@
// ----------------------------------------------------------------------------
// oled_text_console_stream
// Text console for a page-addressed OLED: turns characters into controller
// command and data bytes.
// ----------------------------------------------------------------------------
// Input items (s_valid/s_ready, s_data): put character, set text position or
// load one font byte. Result items (m_valid/m_ready, m_data): one controller
// byte each, flagged command or data, with a repeat count for line fills and
// last set on the final byte of a character.
// Area registers are written through cfg_we/cfg_index/cfg_wdata by the user
// only while idle; the block does not enforce it. Timing: one item at a time.
// A put character sends three position bytes and its glyph columns; breaks
// and wraps first clear the new line. Set position and load send no result.
// The sequencer walks one result per cycle unless stalled; the font RAM is
// read one column ahead so glyph bytes stream without gaps.
// Reset: cursor at the origin, area registers to full screen, result register
// empty. The font RAM is not cleared and must be loaded before use.
// Stall: the result register holds its item while m_ready is low and the
// sequencer waits; no input is taken until the current character finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module oled_text_console_stream
    import otc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // area configuration
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata,

    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,

    // result items
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer: decides which byte goes out next
    otc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .operation (s_data.operation),
        .stat      (stat),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    // cursor, area, font RAM and the result register
    otc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ dv/tb_oled_text_console_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oled_text_console_stream
// Self-checking bench for the OLED text console. A queue-fed driver sends
// put-char, set-position, font-load and no-op items. An item-level model of
// the console predicts every controller byte, and a monitor checks each result
// field by field. The bench runs directed corner cases, then random traffic
// over several text area settings, with random idle on both channels.
// ----------------------------------------------------------------------------
module tb_oled_text_console_stream;
    import otc_pkg::*;

    // operation code 3 is a no-op for the block
    localparam logic [1:0] OP_NOP = 2'd3;

    // cycles with no handshake on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // the longest item is a wrap with line clear; set and load finish with no result
    localparam int DRAIN_CYCLES = 24;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = CFG_ORIGIN_X;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;

    oled_text_console_stream DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Console model: area registers, pixel cursor and font store
    // ------------------------------------------------------------------------
    bit [6:0]  area_ox = 7'd0;
    bit [5:0]  area_oy = 6'd0;
    bit [6:0]  area_ex = 7'd127;
    bit [5:0]  area_ey = 6'd63;
    bit [7:0]  cur_x   = 8'd0;
    bit [7:0]  cur_y   = 8'd0;
    bit [7:0]  font_mem [STORE_SIZE];

    out_item_t char_bytes[$];   // bytes of the item being modeled
    out_item_t want_bytes[$];   // controller bytes still owed by the DUT

    function automatic void emit_byte(input bit [7:0] v, input bit d, input bit [7:0] n);
        out_item_t r;
        r.byte_value   = v;
        r.is_data      = d;
        r.repeat_count = n;
        r.last         = 1'b0;
        char_bytes.push_back(r);
    endfunction

    // column high nibble, column low nibble, page address
    function automatic void send_cursor(input bit [7:0] x, input bit [7:0] y);
        bit [7:0] col;
        col = x + 8'(COLUMN_OFFSET);
        emit_byte(CMD_COL_HI | {4'h0, col[7:4]}, 1'b0, 8'd1);
        emit_byte({4'h0, col[3:0] & COL_LO_MASK}, 1'b0, 8'd1);
        emit_byte(CMD_PAGE + 8'(int'(y) / PAGE_ROWS), 1'b0, 8'd1);
    endfunction

    function automatic void print_char(input bit [7:0] c);
        bit brk;
        int end_x;
        int end_y;
        int y;
        int i;
        brk   = (c == CHAR_CR) || (c == CHAR_LF);
        end_x = (int'(cur_x) + GLYPH_WIDTH) & 255;
        if (brk) begin
            end_x = int'(area_ex) + 1;
        end
        // past the right edge or a line break: next line, wrap at bottom, clear it
        if (end_x > int'(area_ex)) begin
            cur_x = 8'(area_ox);
            end_x = (int'(cur_x) + GLYPH_WIDTH) & 255;
            cur_y = cur_y + 8'(GLYPH_HEIGHT);
            end_y = (int'(cur_y) + GLYPH_HEIGHT) & 255;
            if (end_y > int'(area_ey)) begin
                cur_y = 8'(area_oy);
                end_y = (int'(cur_y) + GLYPH_HEIGHT) & 255;
            end
            for (y = int'(cur_y); y < end_y; y += PAGE_ROWS) begin
                send_cursor(8'(area_ox), 8'(y));
                // zero fill as one result; nothing when the area has no width
                if (area_ex > area_ox) begin
                    emit_byte(8'h00, 1'b1, 8'(area_ex - area_ox));
                end
            end
        end
        send_cursor(cur_x, cur_y);
        if (!brk) begin
            for (i = 0; i < GLYPH_WIDTH; i++) begin
                emit_byte(font_mem[int'(c) * GLYPH_WIDTH + i], 1'b1, 8'd1);
            end
            cur_x = 8'(end_x);
        end
    endfunction

    // Works out the controller bytes of one accepted item and queues them.
    function automatic void console_bytes_for(input in_item_t it);
        int k;
        char_bytes.delete();
        case (it.operation)
            OP_PUT: begin
                print_char(it.char_code);
            end
            OP_SET: begin
                cur_x = 8'(int'(area_ox) + int'(it.text_col) * GLYPH_WIDTH);
                cur_y = 8'(int'(area_oy) + int'(it.text_row) * GLYPH_HEIGHT);
                if (cur_x > 8'(area_ex)) begin
                    cur_x = 8'(area_ox);
                end
                if (cur_y > 8'(area_ey)) begin
                    cur_y = 8'(area_oy);
                end
            end
            OP_LOAD: begin
                // loads past the store are dropped
                if (int'(it.font_addr) < STORE_SIZE) begin
                    font_mem[it.font_addr] = it.font_byte;
                end
            end
            default: begin
            end
        endcase
        if (char_bytes.size() != 0) begin
            char_bytes[char_bytes.size() - 1].last = 1'b1;
            for (k = 0; k < char_bytes.size(); k++) begin
                want_bytes.push_back(char_bytes[k]);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Item generation
    // ------------------------------------------------------------------------
    in_item_t tx_items[$];
    bit       glyph_ready [GLYPH_COUNT];  // every column of the glyph is loaded
    int       items_queued = 0;
    int       items_taken  = 0;
    int       err_count    = 0;
    bit       tx_idle_on   = 1'b1;
    bit       rx_idle_on   = 1'b1;

    // unused fields carry random bits too
    function automatic in_item_t rand_item();
        in_item_t it;
        it.operation = 2'($urandom);
        it.char_code = 8'($urandom);
        it.text_col  = 5'($urandom);
        it.text_row  = 3'($urandom);
        it.font_addr = 11'($urandom);
        it.font_byte = 8'($urandom);
        return it;
    endfunction

    function automatic void queue_item(input in_item_t it);
        tx_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void queue_load(input int addr, input bit [7:0] b);
        in_item_t it;
        it           = rand_item();
        it.operation = OP_LOAD;
        it.font_addr = 11'(addr);
        it.font_byte = b;
        queue_item(it);
    endfunction

    // A glyph is loaded in full before its first use, so no unwritten
    // font entry is ever read.
    function automatic void queue_put(input bit [7:0] c);
        in_item_t it;
        int i;
        if (c != CHAR_CR && c != CHAR_LF && !glyph_ready[c]) begin
            for (i = 0; i < GLYPH_WIDTH; i++) begin
                queue_load(int'(c) * GLYPH_WIDTH + i, 8'($urandom));
            end
            glyph_ready[c] = 1'b1;
        end
        it           = rand_item();
        it.operation = OP_PUT;
        it.char_code = c;
        queue_item(it);
    endfunction

    function automatic void queue_set(input int col, input int row);
        in_item_t it;
        it           = rand_item();
        it.operation = OP_SET;
        it.text_col  = 5'(col);
        it.text_row  = 3'(row);
        queue_item(it);
    endfunction

    function automatic void queue_nop();
        in_item_t it;
        it           = rand_item();
        it.operation = OP_NOP;
        queue_item(it);
    endfunction

    // mostly printable traffic, with breaks, moves, stray loads and no-ops;
    // characters come from a small set spread over the code range so the
    // glyph loads stay few
    function automatic void random_run(input int n);
        int k;
        int pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_put(8'($urandom_range(0, 15) * 17));
            end else if (pick < 65) begin
                queue_put($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end else if (pick < 80) begin
                queue_set($urandom_range(0, 31), $urandom_range(0, 7));
            end else if (pick < 94) begin
                queue_load($urandom_range(0, 2047), 8'($urandom));
            end else begin
                queue_nop();
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input bit [6:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ORIGIN_X: area_ox = val;
            CFG_ORIGIN_Y: area_oy = val[5:0];
            CFG_END_X:    area_ex = val;
            CFG_END_Y:    area_ey = val[5:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_area(input bit [6:0] ox, input bit [6:0] oy,
                            input bit [6:0] ex, input bit [6:0] ey);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_END_X, ex);
        write_reg(CFG_END_Y, ey);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Row registers are 6 bits wide; bit 6 of the write data is dropped.
    task automatic random_area();
        bit [6:0] ox;
        bit [6:0] oy;
        bit [6:0] ex;
        bit [6:0] ey;
        ox    = 7'($urandom_range(0, 120));
        ex    = 7'($urandom_range(int'(ox), 127));
        oy    = 7'(8 * $urandom_range(0, 6));
        ey    = 7'($urandom_range(int'(oy), 63));
        oy[6] = 1'($urandom);
        ey[6] = 1'($urandom);
        set_area(ox, oy, ex, ey);
    endtask

    // Both counters move only at the rising edge, so checking them at the
    // falling edge is race free.
    task automatic drain_all();
        while (items_taken != items_queued || want_bytes.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic settle();
        drain_all();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: one item at a time from tx_items, random gap before each
    // ------------------------------------------------------------------------
    bit s_fire = 1'b0;
    bit m_fire = 1'b0;
    int tx_gap = 0;
    int rx_hold = 0;

    always @(negedge aclk) begin
        logic     nv;
        in_item_t nd;
        nv = s_valid;
        nd = s_data;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_valid || s_fire) begin
            // previous item is gone: idle out the gap, then present the next
            nv = 1'b0;
            if (tx_gap != 0) begin
                tx_gap--;
            end else if (tx_items.size() != 0) begin
                nd     = tx_items.pop_front();
                nv     = 1'b1;
                tx_gap = tx_idle_on ? $urandom_range(0, 3) : 0;
            end
        end
        s_valid <= nv;
        s_data  <= nd;
    end

    // Result side back-pressure: a random stall, possibly none, after every accepted result while rx_idle_on is set.
    always @(negedge aclk) begin
        if (m_fire) begin
            rx_hold = rx_idle_on ? $urandom_range(0, 3) : 0;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input accept, check on result accept, watchdog
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    int idle_cycles = 0;

    always @(posedge aclk) begin
        out_item_t want;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_fire) begin
            items_taken++;
            console_bytes_for(s_data);
        end
        if (m_fire) begin
            if (want_bytes.size() == 0) begin
                flag_error($sformatf("result with nothing expected: byte %02h", m_data.byte_value));
            end else begin
                want = want_bytes.pop_front();
                if (m_data.byte_value !== want.byte_value) begin
                    flag_error($sformatf("byte_value %02h, want %02h",
                                         m_data.byte_value, want.byte_value));
                end
                if (m_data.is_data !== want.is_data) begin
                    flag_error($sformatf("is_data %b, want %b (byte %02h)",
                                         m_data.is_data, want.is_data, want.byte_value));
                end
                if (m_data.repeat_count !== want.repeat_count) begin
                    flag_error($sformatf("repeat_count %0d, want %0d",
                                         m_data.repeat_count, want.repeat_count));
                end
                if (m_data.last !== want.last) begin
                    flag_error($sformatf("last %b, want %b (byte %02h)",
                                         m_data.last, want.last, want.byte_value));
                end
            end
        end
        if (s_fire || m_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset area (full screen)
        queue_put(8'd0);
        queue_load(0, 8'hFF);               // font byte extremes
        queue_load(5, 8'h00);
        queue_put(8'd0);
        queue_put(8'd255);                  // last glyph in the store
        queue_load(STORE_SIZE - 1, 8'hFF);
        queue_put(8'd255);
        queue_put(8'd65);
        queue_put(CHAR_CR);
        queue_put(CHAR_LF);
        queue_load(STORE_SIZE, 8'h5A);      // just past the store: dropped
        queue_load(2047, 8'hA5);            // top of the address range: dropped
        queue_nop();
        queue_set(31, 7);                   // column past the edge clamps to origin
        queue_put(8'd65);
        queue_set(20, 7);
        queue_put(8'd65);
        queue_put(8'd65);                   // right edge on the bottom line: wrap to top
        queue_set(0, 0);
        queue_put(CHAR_CR);
        queue_put(8'd127);
        random_run(20);
        settle();

        // Origin beyond the end: empty fill width, wrap on every line;
        // row writes carry bit 6 high
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        set_area(7'd127, 7'h7F, 7'd0, 7'h40);
        queue_put(8'd65);
        queue_put(CHAR_LF);
        queue_set(0, 0);
        queue_set(31, 7);
        queue_put(8'd0);
        random_run(10);
        settle();

        // Full screen again, no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_area(7'd0, 7'd0, 7'd127, 7'd63);
        random_run(25);
        settle();

        // Random areas; the sender stops once mid-phase until all results are in
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_area();
        random_run(10);
        drain_all();
        random_run(10);
        settle();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        random_area();
        random_run(20);
        settle();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        random_area();
        random_run(20);
        settle();

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/otc_pkg.sv
src/otc_ctrl.sv
src/otc_datapath.sv
src/oled_text_console_stream.sv
dv/tb_oled_text_console_stream.sv
